@@ src/fte_pkg.sv @@
// Shared types and constants of the FAT12 allocation table engine.
package fte_pkg;

  localparam int ReqW   = 2;
  localparam int AddrW  = 13;
  localparam int DataW  = 8;
  localparam int ClusW  = 12;
  localparam int LimW   = 13;
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  localparam logic [ClusW-1:0] FreeCode     = '0;
  localparam logic [LimW-1:0]  FirstClus    = 13'd2;
  localparam logic [LimW-1:0]  LimitReset   = 13'd4096;
  localparam logic [ClusW-1:0] EndLowReset  = 12'd4088;
  localparam logic [ClusW-1:0] EndHighReset = 12'd4095;

  typedef enum logic [ReqW-1:0] {
    REQ_LOAD = 2'd0,
    REQ_READ = 2'd1,
    REQ_SCAN = 2'd2,
    REQ_NOP  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    REG_CLUSTER_LIMIT = 2'd0,
    REG_END_LOW       = 2'd1,
    REG_END_HIGH      = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_READ,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [LimW-1:0]  cluster_limit;
    logic [ClusW-1:0] end_chain_low;
    logic [ClusW-1:0] end_chain_high;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic scan_init;
    logic load_write;
    logic read_issue;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_more;
    logic eval_pend;
  } status_t;

endpackage

@@ src/fte_if.sv @@
// Request and response channel interfaces of the FAT12 allocation table engine.
interface fte_req_if import fte_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [AddrW-1:0] byte_addr;
  logic [DataW-1:0] byte_data;
  logic [ClusW-1:0] cluster;

  modport source (output valid, req_type, byte_addr, byte_data, cluster, input ready);
  modport sink   (input valid, req_type, byte_addr, byte_data, cluster, output ready);
endinterface

interface fte_rsp_if import fte_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ClusW-1:0] entry_value;
  logic             end_of_chain;
  logic             is_free;
  logic [ClusW-1:0] first_free;
  logic [ClusW-1:0] free_count;

  modport source (output valid, entry_value, end_of_chain, is_free, first_free, free_count,
                  input ready);
  modport sink   (input valid, entry_value, end_of_chain, is_free, first_free, free_count,
                  output ready);
endinterface

@@ src/fat12_table_engine.sv @@
// Top level of the FAT12 allocation table engine.
// Takes one transaction at a time; the result sits in an output register, so the next
// transaction is taken while a result waits. A load writes its byte in the load state
// and a read is issued in the read state to the registered read of the two byte banks
// that hold the even and odd table bytes; an unused request type goes straight to the
// result. A scan walks one cluster per cycle through the bank read port, from cluster 2
// up to but not including min(limit, NUM_ENTRIES). The table is not cleared after reset.
module fat12_table_engine import fte_pkg::*; #(
  parameter int NUM_ENTRIES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  fte_req_if.sink           req,
  fte_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  fte_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fte_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (req.ready),
    .status      (status),
    .cmd         (cmd)
  );

  fte_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg          (cfg),
    .in_req_type  (req.req_type),
    .in_byte_addr (req.byte_addr),
    .in_byte_data (req.byte_data),
    .in_cluster   (req.cluster),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .entry_value  (rsp.entry_value),
    .end_of_chain (rsp.end_of_chain),
    .is_free      (rsp.is_free),
    .first_free   (rsp.first_free),
    .free_count   (rsp.free_count)
  );

endmodule

@@ src/fte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [Aw-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [Aw-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/fte_regs.sv @@
// APB configuration registers of the FAT12 allocation table engine.
module fte_regs import fte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[PaddrW-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cluster_limit  <= LimitReset;
      cfg.end_chain_low  <= EndLowReset;
      cfg.end_chain_high <= EndHighReset;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_CLUSTER_LIMIT: cfg.cluster_limit  <= pwdata[LimW-1:0];
        REG_END_LOW:       cfg.end_chain_low  <= pwdata[ClusW-1:0];
        REG_END_HIGH:      cfg.end_chain_high <= pwdata[ClusW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CLUSTER_LIMIT: prdata = PdataW'(cfg.cluster_limit);
      REG_END_LOW:       prdata = PdataW'(cfg.end_chain_low);
      REG_END_HIGH:      prdata = PdataW'(cfg.end_chain_high);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ src/fte_ctrl.sv @@
// Transaction sequencer of the FAT12 allocation table engine.
module fte_ctrl import fte_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [ReqW-1:0] in_req_type,
  output logic            in_ready,
  input  status_t         status,
  output cmd_t            cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (req_type_t'(in_req_type))
            REQ_LOAD: state_next = S_LOAD;
            REQ_READ: state_next = S_READ;
            REQ_SCAN: begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
            REQ_NOP:  state_next = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_write = 1'b1;
        state_next     = S_DONE;
      end
      S_READ: begin
        cmd.read_issue = 1'b1;
        state_next     = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (!status.scan_more && !status.eval_pend) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction accepted while one is in progress");

endmodule

@@ src/fte_dp.sv @@
// Datapath of the FAT12 allocation table engine: byte banks, unpack, scan and result.
module fte_dp import fte_pkg::*; #(
  parameter int NUM_ENTRIES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          status,
  input  cfg_t             cfg,
  input  logic [ReqW-1:0]  in_req_type,
  input  logic [AddrW-1:0] in_byte_addr,
  input  logic [DataW-1:0] in_byte_data,
  input  logic [ClusW-1:0] in_cluster,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ClusW-1:0] entry_value,
  output logic             end_of_chain,
  output logic             is_free,
  output logic [ClusW-1:0] first_free,
  output logic [ClusW-1:0] free_count
);

  localparam int TableDepth = (3 * NUM_ENTRIES + 1) / 2;
  localparam int BankDepth  = (TableDepth + 1) / 2;
  localparam int BankAw     = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam logic [AddrW-1:0] DepthAddr = AddrW'(TableDepth);
  localparam logic [LimW-1:0]  LimMax    = LimW'(NUM_ENTRIES);

  req_type_t        req_type_q;
  logic [AddrW-1:0] byte_addr_q;
  logic [DataW-1:0] byte_data_q;
  logic [ClusW-1:0] cluster_q;

  logic [LimW-1:0]  scan_n;
  logic [LimW-1:0]  lim_eff;
  logic             scan_issue;
  logic             rd_issue;
  logic [ClusW-1:0] rd_clus;
  logic [AddrW-1:0] rd_start;
  logic [AddrW-1:0] rd_next;
  logic [AddrW-2:0] rd_half;
  logic [AddrW-2:0] rd_half_inc;
  logic [AddrW-2:0] wr_half;
  logic [BankAw-1:0] even_raddr;
  logic [BankAw-1:0] odd_raddr;
  logic             wr_ok;
  logic [DataW-1:0] even_rdata;
  logic [DataW-1:0] odd_rdata;

  logic             rd_valid;
  logic             rd_scan;
  logic             rd_swap;
  logic             rd_b0_ok;
  logic             rd_b1_ok;
  logic             rd_odd;
  logic [ClusW-1:0] rd_clus_q;

  logic [DataW-1:0] b0;
  logic [DataW-1:0] b1;
  logic [ClusW-1:0] entry;
  logic             entry_free;

  logic [ClusW-1:0] acc_first;
  logic [ClusW-1:0] acc_count;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_q  <= req_type_t'(in_req_type);
      byte_addr_q <= in_byte_addr;
      byte_data_q <= in_byte_data;
      cluster_q   <= in_cluster;
    end
  end

  assign lim_eff    = (cfg.cluster_limit > LimMax) ? LimMax : cfg.cluster_limit;
  assign scan_issue = cmd.scan_step && (scan_n < lim_eff);
  assign rd_issue   = cmd.read_issue || scan_issue;

  assign rd_clus     = cmd.scan_step ? scan_n[ClusW-1:0] : cluster_q;
  assign rd_start    = {1'b0, rd_clus} + AddrW'(rd_clus[ClusW-1:1]);
  assign rd_next     = rd_start + AddrW'(1);
  assign rd_half     = rd_start[AddrW-1:1];
  assign rd_half_inc = rd_half + (AddrW-1)'(1);
  assign even_raddr  = rd_start[0] ? rd_half_inc[BankAw-1:0] : rd_half[BankAw-1:0];
  assign odd_raddr   = rd_half[BankAw-1:0];

  assign wr_half = byte_addr_q[AddrW-1:1];
  assign wr_ok   = cmd.load_write && (byte_addr_q < DepthAddr);

  fte_ram #(.Width(DataW), .Depth(BankDepth)) u_even_bank (
    .clk   (clk),
    .we    (wr_ok && !byte_addr_q[0]),
    .waddr (wr_half[BankAw-1:0]),
    .wdata (byte_data_q),
    .re    (rd_issue),
    .raddr (even_raddr),
    .rdata (even_rdata)
  );

  fte_ram #(.Width(DataW), .Depth(BankDepth)) u_odd_bank (
    .clk   (clk),
    .we    (wr_ok && byte_addr_q[0]),
    .waddr (wr_half[BankAw-1:0]),
    .wdata (byte_data_q),
    .re    (rd_issue),
    .raddr (odd_raddr),
    .rdata (odd_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_scan   <= scan_issue;
      rd_swap   <= rd_start[0];
      rd_b0_ok  <= rd_start < DepthAddr;
      rd_b1_ok  <= rd_next < DepthAddr;
      rd_odd    <= rd_clus[0];
      rd_clus_q <= rd_clus;
    end
  end

  assign b0         = rd_b0_ok ? (rd_swap ? odd_rdata : even_rdata) : '0;
  assign b1         = rd_b1_ok ? (rd_swap ? even_rdata : odd_rdata) : '0;
  assign entry      = rd_odd ? {b1, b0[DataW-1:4]} : {b1[3:0], b0};
  assign entry_free = (entry == FreeCode);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_n    <= FirstClus;
      acc_first <= '0;
      acc_count <= '0;
    end else begin
      if (scan_issue) begin
        scan_n <= scan_n + LimW'(1);
      end
      if (rd_valid && rd_scan && entry_free) begin
        if (acc_first == '0) begin
          acc_first <= rd_clus_q;
        end
        acc_count <= acc_count + ClusW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      entry_value  <= '0;
      end_of_chain <= 1'b0;
      is_free      <= 1'b0;
      first_free   <= '0;
      free_count   <= '0;
      unique case (req_type_q)
        REQ_READ: begin
          entry_value  <= entry;
          end_of_chain <= (entry >= cfg.end_chain_low) && (entry <= cfg.end_chain_high);
          is_free      <= entry_free;
        end
        REQ_SCAN: begin
          first_free <= acc_first;
          free_count <= acc_count;
        end
        REQ_LOAD, REQ_NOP: ;
      endcase
    end
  end

  assign status.out_free  = !out_valid || out_ready;
  assign status.scan_more = scan_n < lim_eff;
  assign status.eval_pend = rd_valid;

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result overwrites one not yet taken");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (scan_n <= lim_eff || scan_n == FirstClus))
    else $error("scan pointer ran past the limit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> ({1'b0, acc_count} + FirstClus <= scan_n))
    else $error("free count exceeds clusters scanned");

endmodule
